// ===== hdl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and fixed field widths for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned ActionWidth = 3;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned CountWidth  = 5;

  typedef enum logic [ActionWidth-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_CLEAR      = 3'd4
  } action_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic latch_in;
    logic execute;
    logic read_mem;
    logic load_out;
  } dq_cmd_t;

endpackage

// ===== hdl/dq_in_if.sv =====
// ----------------------------------------------------------------------------
// dq_in_if
// Request channel: one action and one value per transaction.
// ----------------------------------------------------------------------------
interface dq_in_if
  import dq_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [ActionWidth-1:0] action;
  logic [ValueWidth-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

// ===== hdl/dq_out_if.sv =====
// ----------------------------------------------------------------------------
// dq_out_if
// Result channel: queue status after each action.
// ----------------------------------------------------------------------------
interface dq_out_if
  import dq_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [ValueWidth-1:0]  front_value;
  logic [ValueWidth-1:0]  back_value;
  logic [CountWidth-1:0]  element_count;
  logic                  is_empty;
  logic                  is_full;
  logic                  push_dropped;

  modport source (
    output valid, output front_value, output back_value, output element_count,
    output is_empty, output is_full, output push_dropped, input ready
  );
  modport sink (
    input valid, input front_value, input back_value, input element_count,
    input is_empty, input is_full, input push_dropped, output ready
  );
endinterface

// ===== hdl/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: accept, update and write, read both ends, hand off the result.
// ----------------------------------------------------------------------------
module dq_ctrl
  import dq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.latch_in = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.execute  = (state_q == ST_EXEC);
    cmd_o.read_mem = (state_q == ST_READ);
    cmd_o.load_out = (state_q == ST_DONE) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces the old one, otherwise it stays until taken
      out_valid_q <= cmd_o.load_out || (out_valid_q && !out_ready_i);
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: state_q <= ST_READ;
        ST_READ: state_q <= ST_DONE;
        ST_DONE: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/dq_datapath.sv =====
// ----------------------------------------------------------------------------
// dq_datapath
// Ring store with head index and count, end reads and the result register.
// ----------------------------------------------------------------------------
module dq_datapath
  import dq_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dq_cmd_t               cmd_i,
  input  logic [ActionWidth-1:0] action_i,
  input  logic [ValueWidth-1:0]  value_i,
  output logic [ValueWidth-1:0]  front_value_o,
  output logic [ValueWidth-1:0]  back_value_o,
  output logic [CountWidth-1:0]  element_count_o,
  output logic                  is_empty_o,
  output logic                  is_full_o,
  output logic                  push_dropped_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned SumW = CntW + 1;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  action_e               act_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [IdxW-1:0]       head_q, head_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  dropped_q, dropped_d;
  logic [DATA_WIDTH-1:0] rd_front_q, rd_back_q;

  logic                  wr_en;
  logic [IdxW-1:0]       wr_addr;
  logic [IdxW-1:0]       head_dec, head_inc, tail_addr, back_addr;
  logic [SumW-1:0]       tail_sum, back_sum;
  logic                  full, empty;
  logic [DATA_WIDTH+ValueWidth-1:0] val_ext;
  logic [DATA_WIDTH+ValueWidth-1:0] front_ext, back_ext;
  logic [CntW+CountWidth-1:0]       count_ext;

  assign val_ext = {{DATA_WIDTH{1'b0}}, value_i};
  assign full    = (count_q == CntW'(CAPACITY));
  assign empty   = (count_q == '0);

  assign head_dec = (head_q == '0) ? IdxW'(CAPACITY - 1) : head_q - 1'b1;
  assign head_inc = (head_q == IdxW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

  // head + count stays below twice the capacity, so one subtract wraps it
  always_comb begin
    tail_sum = SumW'(head_q) + SumW'(count_q);
    if (tail_sum >= SumW'(CAPACITY)) begin
      tail_sum = tail_sum - SumW'(CAPACITY);
    end
    back_sum = SumW'(head_q) + SumW'(count_q) - 1'b1;
    if (empty) begin
      back_sum = SumW'(head_q);
    end else if (back_sum >= SumW'(CAPACITY)) begin
      back_sum = back_sum - SumW'(CAPACITY);
    end
  end
  assign tail_addr = tail_sum[IdxW-1:0];
  assign back_addr = back_sum[IdxW-1:0];

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    dropped_d = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = tail_addr;
    case (act_q)
      ACT_PUSH_FRONT: begin
        if (full) begin
          dropped_d = 1'b1;
        end else begin
          head_d  = head_dec;
          wr_en   = 1'b1;
          wr_addr = head_dec;
          count_d = count_q + 1'b1;
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          dropped_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (!empty) begin
          head_d  = head_inc;
          count_d = count_q - 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (!empty) begin
          count_d = count_q - 1'b1;
        end
      end
      ACT_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.execute) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      act_q <= action_e'(action_i);
      val_q <= val_ext[DATA_WIDTH-1:0];
    end
    if (cmd_i.execute) begin
      dropped_q <= dropped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && wr_en) begin
      mem[wr_addr] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_mem) begin
      rd_front_q <= mem[head_q];
      rd_back_q  <= mem[back_addr];
    end
  end

  assign front_ext = {{ValueWidth{1'b0}}, rd_front_q};
  assign back_ext  = {{ValueWidth{1'b0}}, rd_back_q};
  assign count_ext = {{CountWidth{1'b0}}, count_q};

  // result register, zero values when the queue is empty
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      front_value_o   <= empty ? '0 : front_ext[ValueWidth-1:0];
      back_value_o    <= empty ? '0 : back_ext[ValueWidth-1:0];
      element_count_o <= count_ext[CountWidth-1:0];
      is_empty_o      <= empty;
      is_full_o       <= full;
      push_dropped_o  <= dropped_q;
    end
  end

endmodule

// ===== hdl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue in a ring store: push and pop at either end, or clear.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one action (push front, push back, pop front, pop back,
//   clear) and a value per transaction; out_o returns one result per
//   request with the front and back elements, the count and the empty,
//   full and push-dropped flags as they stand after the action.
//   Each request walks four steps: accept, update head/count and write the
//   ring store, read both ends from the store's registered read ports, and
//   load the result register. The result is valid once the load step is
//   done; in_i takes no new request until the last has left the sequencer;
//   the write-then-registered-read order on the store sets these steps.
//   A pending result sits in the output register while the next request
//   is accepted; if the receiver stalls, the following result waits in the
//   sequencer and in_i stays not ready until it can be handed off.
//   Reset empties the queue (head and count cleared); store contents are
//   not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dq_in_if.sink     in_i,
  dq_out_if.source  out_o
);

  dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  dq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .action_i        (in_i.action),
    .value_i         (in_i.value),
    .front_value_o   (out_o.front_value),
    .back_value_o    (out_o.back_value),
    .element_count_o (out_o.element_count),
    .is_empty_o      (out_o.is_empty),
    .is_full_o       (out_o.is_full),
    .push_dropped_o  (out_o.push_dropped)
  );

endmodule
